// ----- hw/rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search core.
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IDX_IN_W   = 10;
    localparam int POS_W      = 10;
    localparam int KEY_IN_W   = 32;
    localparam int COUNT_W    = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXACT = 2'd1,
        OP_LOWER = 2'd2,
        OP_UPPER = 2'd3
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic hit;
    } ctrl_t;

endpackage

// ----- hw/rtl/sorted_table_binary_search_core.sv -----
// Top level of the sorted table binary search core: entry, step chain, result, registers.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_ready  | operation, entry_index, item_value
//  output   | out_valid / out_ready| found, position
//  config   | APB psel/penable     | entry_count at byte address 0
//
// Each item passes clog2(TABLE_DEPTH)+1 halving steps, each with a table read stage
// and a compare stage, and then a query loads the result register.
// One item enters per cycle while the chain is not frozen.
// Each step keeps its own table copy; a write updates it as it passes the step.
// Reset clears valid bits and entry_count; table contents stay undefined until written.
// The chain freezes only while a query sits in the last step and the result register
// holds a beat not yet taken.
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            operation,
    input  logic [stbs_pkg::IDX_IN_W-1:0]         entry_index,
    input  logic signed [stbs_pkg::KEY_IN_W-1:0]  item_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  found,
    output logic [stbs_pkg::POS_W-1:0]            position,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [stbs_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [stbs_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [stbs_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int CNT_W = $clog2(TABLE_DEPTH+1);
    localparam int STEPS = $clog2(TABLE_DEPTH) + 1;
    localparam int WIDE_W = CNT_W + stbs_pkg::COUNT_W + stbs_pkg::POS_W;
    localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(TABLE_DEPTH);

    stbs_pkg::ctrl_t        ctrl_w [STEPS+1];
    logic [CNT_W-1:0]       lo_w   [STEPS+1];
    logic [CNT_W-1:0]       hi_w   [STEPS+1];
    logic [VALUE_WIDTH-1:0] key_w  [STEPS+1];

    logic [stbs_pkg::COUNT_W-1:0] entry_count_reg;
    logic [0:0]                   reg_idx;
    logic                         cfg_write;

    logic [WIDE_W-1:0]                        count_wide;
    logic [WIDE_W-1:0]                        idx_wide;
    logic [WIDE_W-1:0]                        cov_wide;
    logic [CNT_W-1:0]                         count_cov;
    logic signed [VALUE_WIDTH+stbs_pkg::KEY_IN_W-1:0] key_ext;
    stbs_pkg::op_t                            op_in;
    logic                                     wr_ok;

    logic                   advance;
    logic                   last_query;
    logic                   res_found;
    logic [CNT_W-1:0]       res_pos;
    logic [WIDE_W-1:0]      res_pos_wide;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [WIDE_W-1:0]      pos_wide;

    // configuration port
    assign reg_idx   = paddr[stbs_pkg::CFG_ADDR_W-1 -: 1];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_write && reg_idx == stbs_pkg::REG_ENTRY_COUNT)
        begin
            entry_count_reg <= pwdata[stbs_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == stbs_pkg::REG_ENTRY_COUNT)
        begin
            prdata = {{(stbs_pkg::CFG_DATA_W-stbs_pkg::COUNT_W){1'b0}}, entry_count_reg};
        end
    end

    // clamp the count to the table depth
    always_comb
    begin
        count_wide = {{(WIDE_W-stbs_pkg::COUNT_W){1'b0}}, entry_count_reg};
        cov_wide   = (count_wide > DEPTH_WIDE) ? DEPTH_WIDE : count_wide;
        count_cov  = cov_wide[CNT_W-1:0];
    end

    // entry: writes carry their address in lo; drop writes beyond the table
    always_comb
    begin
        op_in      = stbs_pkg::op_t'(operation);
        idx_wide   = {{(WIDE_W-stbs_pkg::IDX_IN_W){1'b0}}, entry_index};
        wr_ok      = idx_wide < DEPTH_WIDE;
        key_ext    = {{VALUE_WIDTH{item_value[stbs_pkg::KEY_IN_W-1]}}, item_value};
        ctrl_w[0].valid = in_valid && (op_in != stbs_pkg::OP_WRITE || wr_ok);
        ctrl_w[0].op    = op_in;
        ctrl_w[0].hit   = 1'b0;
        lo_w[0]    = (op_in == stbs_pkg::OP_WRITE) ? idx_wide[CNT_W-1:0] : '0;
        hi_w[0]    = count_cov;
        key_w[0]   = key_ext[VALUE_WIDTH-1:0];
    end

    generate
        for (genvar s = 0; s < STEPS; s++)
        begin : g_step
            stbs_step #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .up_ctrl (ctrl_w[s]),
                .up_lo   (lo_w[s]),
                .up_hi   (hi_w[s]),
                .up_key  (key_w[s]),
                .dn_ctrl (ctrl_w[s+1]),
                .dn_lo   (lo_w[s+1]),
                .dn_hi   (hi_w[s+1]),
                .dn_key  (key_w[s+1])
            );
        end
    endgenerate

    // result
    assign last_query = ctrl_w[STEPS].valid && (ctrl_w[STEPS].op != stbs_pkg::OP_WRITE);
    assign advance    = !out_valid_reg || out_ready || !last_query;
    assign in_ready   = advance;

    always_comb
    begin
        if (ctrl_w[STEPS].op == stbs_pkg::OP_EXACT)
        begin
            res_found = ctrl_w[STEPS].hit;
        end
        else
        begin
            res_found = lo_w[STEPS] < count_cov;
        end
        res_pos      = res_found ? lo_w[STEPS] : '0;
        res_pos_wide = {{(WIDE_W-CNT_W){1'b0}}, res_pos};

        out_valid_next = out_valid_reg && !out_ready;
        if (advance && last_query)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_query)
        begin
            found_reg <= res_found;
            pos_reg   <= res_pos_wide[CNT_W-1:0];
        end
    end

    assign pos_wide  = {{(WIDE_W-CNT_W){1'b0}}, pos_reg};
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = pos_wide[stbs_pkg::POS_W-1:0];

`ifndef SYNTHESIS
    a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> pos_reg == '0)
        else $error("result without a hit carries a nonzero position");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> pos_reg < count_cov)
        else $error("reported position lies outside the covered entries");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && last_query)
        else $error("input stalled without a blocked result");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(ctrl_w[STEPS]) && $stable(lo_w[STEPS]))
        else $error("last step moved during a stall");
`endif

endmodule

// ----- hw/rtl/stbs_step.sv -----
// One halving step: a private table copy, a read stage and a compare stage.
module stbs_step #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  stbs_pkg::ctrl_t                     up_ctrl,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    up_lo,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    up_hi,
    input  logic [VALUE_WIDTH-1:0]              up_key,
    output stbs_pkg::ctrl_t                     dn_ctrl,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    dn_lo,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    dn_hi,
    output logic [VALUE_WIDTH-1:0]              dn_key
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH+1);

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    // read stage
    stbs_pkg::ctrl_t        a_ctrl_reg;
    logic [CNT_W-1:0]       a_lo_reg;
    logic [CNT_W-1:0]       a_hi_reg;
    logic [CNT_W-1:0]       a_mid_reg;
    logic [VALUE_WIDTH-1:0] a_key_reg;
    logic                   a_act_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;

    // compare stage
    stbs_pkg::ctrl_t        b_ctrl_reg;
    logic [CNT_W-1:0]       b_lo_reg;
    logic [CNT_W-1:0]       b_hi_reg;
    logic [VALUE_WIDTH-1:0] b_key_reg;

    logic [CNT_W-1:0]       span;
    logic [CNT_W-1:0]       half;
    logic [CNT_W-1:0]       mid;
    logic                   act;
    logic                   wr_en;

    stbs_pkg::ctrl_t        b_ctrl_next;
    logic [CNT_W-1:0]       b_lo_next;
    logic [CNT_W-1:0]       b_hi_next;
    logic                   less;
    logic                   equal;
    logic                   go_right;

    always_comb
    begin
        span  = up_hi - up_lo;
        act   = up_ctrl.valid && (up_ctrl.op != stbs_pkg::OP_WRITE) && !up_ctrl.hit
                && (up_lo < up_hi);
        // exact search uses an inclusive right bound
        if (up_ctrl.op == stbs_pkg::OP_EXACT)
        begin
            half = (span - CNT_W'(1)) >> 1;
        end
        else
        begin
            half = span >> 1;
        end
        mid   = up_lo + half;
        wr_en = advance && up_ctrl.valid && (up_ctrl.op == stbs_pkg::OP_WRITE);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[up_lo[IDX_W-1:0]] <= up_key;
        end
        if (advance)
        begin
            rdata_reg <= mem[mid[IDX_W-1:0]];
            a_lo_reg  <= up_lo;
            a_hi_reg  <= up_hi;
            a_mid_reg <= mid;
            a_key_reg <= up_key;
            a_act_reg <= act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            a_ctrl_reg <= up_ctrl;
        end
    end

    always_comb
    begin
        less        = $signed(rdata_reg) < $signed(a_key_reg);
        equal       = rdata_reg == a_key_reg;
        go_right    = (a_ctrl_reg.op == stbs_pkg::OP_UPPER) ? (less || equal) : less;
        b_ctrl_next = a_ctrl_reg;
        b_lo_next   = a_lo_reg;
        b_hi_next   = a_hi_reg;
        if (a_act_reg)
        begin
            priority if (a_ctrl_reg.op == stbs_pkg::OP_EXACT && equal)
            begin
                // stop here; later steps pass the hit through
                b_ctrl_next.hit = 1'b1;
                b_lo_next       = a_mid_reg;
            end
            else if (go_right)
            begin
                b_lo_next = a_mid_reg + CNT_W'(1);
            end
            else
            begin
                b_hi_next = a_mid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_lo_reg  <= b_lo_next;
            b_hi_reg  <= b_hi_next;
            b_key_reg <= a_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    assign dn_ctrl = b_ctrl_reg;
    assign dn_lo   = b_lo_reg;
    assign dn_hi   = b_hi_reg;
    assign dn_key  = b_key_reg;

endmodule

// ----- tb/sorted_table_binary_search_core_tb.sv -----
// Testbench for the sorted table binary search core: directed and random searches on a shadow table.
`timescale 1ns / 100ps

module sorted_table_binary_search_core_tb;

    localparam int IDX_IN_W   = stbs_pkg::IDX_IN_W;
    localparam int POS_W      = stbs_pkg::POS_W;
    localparam int KEY_IN_W   = stbs_pkg::KEY_IN_W;
    localparam int COUNT_W    = stbs_pkg::COUNT_W;
    localparam int CFG_ADDR_W = stbs_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = stbs_pkg::CFG_DATA_W;

    localparam int DEPTH       = stbs_pkg::DEF_TABLE_DEPTH;
    localparam int LATENCY     = 2 * ($clog2(DEPTH) + 1);
    localparam int SETTLE      = LATENCY + 8;
    localparam int ITEM_TARGET = 1900;

    localparam logic signed [KEY_IN_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_IN_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic [CFG_ADDR_W-1:0] ENTRY_COUNT_ADDR =
        CFG_ADDR_W'({stbs_pkg::REG_ENTRY_COUNT, 2'b00});

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 operation;
    logic [IDX_IN_W-1:0]        entry_index;
    logic signed [KEY_IN_W-1:0] item_value;
    logic                       out_valid;
    logic                       out_ready;
    logic                       found;
    logic [POS_W-1:0]           position;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [CFG_ADDR_W-1:0]      paddr;
    logic [CFG_DATA_W-1:0]      pwdata;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;

    logic signed [KEY_IN_W-1:0] shadow_table [DEPTH];
    logic [COUNT_W-1:0]         shadow_count;
    lookup_t                    expected_lookups [$];

    int mismatches  = 0;
    int items_sent  = 0;
    int hold_cycles = 0;
    bit idling      = 1'b1;

    sorted_table_binary_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .entry_index (entry_index),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int covered_entries();
        return (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    endfunction

    // Apply one beat to the shadow table; queries push the search outcome.
    function automatic void predict_lookup(stbs_pkg::op_t op, logic [IDX_IN_W-1:0] idx,
                                           logic signed [KEY_IN_W-1:0] key);
        int      lo;
        int      hi;
        int      mid;
        int      n;
        logic    go_right;
        lookup_t r;
        n  = covered_entries();
        lo = 0;
        hi = n;
        r  = '0;
        if (op == stbs_pkg::OP_WRITE)
        begin
            shadow_table[idx] = key;
            return;
        end
        if (op == stbs_pkg::OP_EXACT)
        begin
            // inclusive right bound, so the midpoint leans left
            while (lo < hi)
            begin
                mid = lo + (hi - 1 - lo) / 2;
                if (shadow_table[mid] == key)
                begin
                    r.found    = 1'b1;
                    r.position = POS_W'(mid);
                    break;
                end
                if (shadow_table[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
        end
        else
        begin
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                go_right = (op == stbs_pkg::OP_LOWER) ? (shadow_table[mid] < key)
                                                      : (shadow_table[mid] <= key);
                if (go_right)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < n)
            begin
                r.found    = 1'b1;
                r.position = POS_W'(lo);
            end
        end
        expected_lookups.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Mostly keys taken from the covered entries or next to them, then extremes and noise.
    function automatic logic signed [KEY_IN_W-1:0] pick_key();
        int                         n;
        int                         r;
        logic signed [KEY_IN_W-1:0] v;
        n = covered_entries();
        r = $urandom_range(0, 99);
        if (n > 0 && r < 60)
        begin
            v = shadow_table[$urandom_range(0, n - 1)];
            if (r >= 40)
                v = (r < 50) ? v + 1 : v - 1;
            return v;
        end
        if (r < 70)
            return ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
        return $urandom;
    endfunction

    task automatic send_item(stbs_pkg::op_t op, logic [IDX_IN_W-1:0] idx,
                             logic signed [KEY_IN_W-1:0] val);
        int gap;
        gap = idling ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        item_value  <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_lookup(op, idx, val);
        items_sent++;
    endtask

    // Drop valid, drain all results, then let trailing writes leave the step chain.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_entry_count(logic [CFG_DATA_W-1:0] word);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        shadow_count = word[COUNT_W-1:0];
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== CFG_DATA_W'(shadow_count))
        begin
            $display("%0t: entry_count readback expected %0d actual %0d",
                     $time, shadow_count, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write entries 0..n-1 in ascending order with runs of duplicates.
    task automatic load_sorted(int n);
        longint      v;
        int unsigned step_max;
        int          mode;
        mode = $urandom_range(0, 2);
        step_max = (mode == 0) ? 2 : (mode == 1) ? (1 << 20) : 32'h8000_0000;
        if (mode == 2 || $urandom_range(0, 7) == 0)
            v = longint'(KEY_MIN);
        else
            v = longint'($signed($urandom));
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) != 0)
                v = v + $urandom_range(0, step_max);
            if (v > longint'(KEY_MAX))
                v = longint'(KEY_MAX);
            send_item(stbs_pkg::OP_WRITE, IDX_IN_W'(i), KEY_IN_W'(v));
        end
    endtask

    task automatic run_queries(int count, int noise_pct);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(stbs_pkg::OP_WRITE, IDX_IN_W'($urandom), KEY_IN_W'($urandom));
            else
                send_item(stbs_pkg::op_t'($urandom_range(1, 3)), IDX_IN_W'($urandom),
                          pick_key());
        end
    endtask

    task automatic test_empty_table();
        send_item(stbs_pkg::OP_EXACT, '0, KEY_MIN);
        send_item(stbs_pkg::OP_LOWER, '1, KEY_MAX);
        send_item(stbs_pkg::OP_UPPER, '0, 0);
        wait_idle();
        set_entry_count(0);
        send_item(stbs_pkg::OP_EXACT, '1, 0);
        wait_idle();
    endtask

    task automatic test_small_table();
        logic signed [KEY_IN_W-1:0] entries [8] = '{KEY_MIN, KEY_MIN, -5, 0, 0, 0, 7, KEY_MAX};
        stbs_pkg::op_t q_ops [11] = '{stbs_pkg::OP_EXACT, stbs_pkg::OP_EXACT,
                                      stbs_pkg::OP_EXACT, stbs_pkg::OP_EXACT,
                                      stbs_pkg::OP_EXACT, stbs_pkg::OP_LOWER,
                                      stbs_pkg::OP_UPPER, stbs_pkg::OP_LOWER,
                                      stbs_pkg::OP_UPPER, stbs_pkg::OP_LOWER,
                                      stbs_pkg::OP_UPPER};
        logic signed [KEY_IN_W-1:0] q_keys [11] = '{-5, 0, 3, KEY_MIN, KEY_MAX, 0,
                                                   0, KEY_MIN, KEY_MAX, KEY_MAX, -6};
        for (int i = 0; i < 8; i++)
            send_item(stbs_pkg::OP_WRITE, IDX_IN_W'(i), entries[i]);
        wait_idle();
        set_entry_count(8);
        for (int i = 0; i < 11; i++)
            send_item(q_ops[i], (i % 2 == 0) ? '0 : '1, q_keys[i]);
        wait_idle();
    endtask

    task automatic test_full_table();
        idling = 1'b0;
        load_sorted(DEPTH);
        wait_idle();
        set_entry_count(DEPTH);
        idling = 1'b1;
        run_queries(20, 0);
        // hold the output so the chain fills and input stalls
        hold_cycles = 300;
        run_queries(150, 0);
        wait_idle();
    endtask

    task automatic test_count_overflow();
        set_entry_count(DEPTH + 1);
        run_queries(40, 5);
        wait_idle();
        set_entry_count(32'hffff_ffff);
        run_queries(40, 5);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int                    n;
        int                    r;
        logic [COUNT_W-1:0]    cnt;
        logic [CFG_DATA_W-1:0] word;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                n = 0;
            else if (r < 75)
                n = $urandom_range(1, 32);
            else if (r < 95)
                n = $urandom_range(33, 128);
            else
                n = $urandom_range(129, 400);
            idling = ($urandom_range(0, 3) != 0);
            load_sorted(n);
            wait_idle();
            cnt  = ($urandom_range(0, 99) < 80) ? COUNT_W'(n)
                                                : COUNT_W'($urandom_range(0, 2047));
            word = CFG_DATA_W'(cnt);
            if ($urandom_range(0, 3) == 0)
                word[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W-COUNT_W)'($urandom);
            set_entry_count(word);
            run_queries($urandom_range(15, 50), 8);
            wait_idle();
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected beat found=%0b position=%0d",
                         $time, found, position);
                mismatches++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, found);
                    mismatches++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = stbs_pkg::OP_WRITE;
        entry_index  = '0;
        item_value   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        shadow_count = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_small_table();
        test_full_table();
        test_count_overflow();
        test_random_phases();
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
